@@ rtl/pedf_pkg.sv @@
// Shared types, constants and helpers for the photon event packet deframer.
package pedf_pkg;

    localparam int WORD_W     = 16;
    localparam int COUNT_W    = 8;
    localparam int WIDTH_W    = 5;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [COUNT_W-1:0] MAX_PHOTONS  = 8'd244;
    localparam logic [WORD_W-1:0]  HEADER_WORDS = 16'd3;
    localparam logic [WORD_W-1:0]  POS_MAX      = 16'hffff;

    // register index in paddr[3:2]
    localparam logic [1:0] REG_X_WIDTH     = 2'd0;
    localparam logic [1:0] REG_Y_WIDTH     = 2'd1;
    localparam logic [1:0] REG_PULSE_WIDTH = 2'd2;

    localparam logic [WIDTH_W-1:0] X_WIDTH_RST     = 5'd12;
    localparam logic [WIDTH_W-1:0] Y_WIDTH_RST     = 5'd12;
    localparam logic [WIDTH_W-1:0] PULSE_WIDTH_RST = 5'd8;

    localparam logic KIND_PHOTON  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              end_of_packet;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic [WORD_W-1:0]  x_coord;
        logic [WORD_W-1:0]  y_coord;
        logic [WORD_W-1:0]  pulse_height;
        logic [WORD_W-1:0]  packet_number;
        logic [COUNT_W-1:0] photons_delivered;
    } out_item_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] x_width;
        logic [WIDTH_W-1:0] y_width;
        logic [WIDTH_W-1:0] pulse_width;
    } widths_t;

    // One queued word's worth of results: a photon, a summary, or both.
    typedef struct packed {
        logic               photon;
        logic               summary;
        logic [WORD_W-1:0]  x_coord;
        logic [WORD_W-1:0]  y_coord;
        logic [WORD_W-1:0]  pulse_height;
        logic [WORD_W-1:0]  packet_number;
        logic [COUNT_W-1:0] count;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    function automatic logic [WORD_W-1:0] width_mask(input logic [WIDTH_W-1:0] w);
        logic [WORD_W:0] one_hot;
        begin
            one_hot = (WORD_W+1)'(1) << w;
            if (w >= WIDTH_W'(WORD_W))
                width_mask = '1;
            else
                width_mask = WORD_W'(one_hot - (WORD_W+1)'(1));
        end
    endfunction

endpackage

@@ rtl/pedf_front.sv @@
// Front end: tracks packet position, masks fields and builds result entries.
module pedf_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  pedf_pkg::in_item_t   in_data,
    input  pedf_pkg::widths_t    widths,
    output logic                 push,
    output pedf_pkg::entry_t     entry
);

    logic [pedf_pkg::WORD_W-1:0]  pos_reg, pos_next;
    logic [pedf_pkg::COUNT_W-1:0] limit_reg, limit_next;
    logic [pedf_pkg::WORD_W-1:0]  pid_reg, pid_next;
    logic [pedf_pkg::WORD_W-1:0]  hx_reg, hx_next;
    logic [pedf_pkg::WORD_W-1:0]  hy_reg, hy_next;
    logic [1:0]                   phase_reg, phase_next;
    logic [pedf_pkg::COUNT_W-1:0] emitted_reg, emitted_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pos_reg     <= '0;
            limit_reg   <= '0;
            pid_reg     <= '0;
            hx_reg      <= '0;
            hy_reg      <= '0;
            phase_reg   <= '0;
            emitted_reg <= '0;
        end else begin
            pos_reg     <= pos_next;
            limit_reg   <= limit_next;
            pid_reg     <= pid_next;
            hx_reg      <= hx_next;
            hy_reg      <= hy_next;
            phase_reg   <= phase_next;
            emitted_reg <= emitted_next;
        end
    end

    always_comb begin
        logic [pedf_pkg::WORD_W-1:0] w;
        logic                        hit;
        w            = in_data.word;
        hit          = 1'b0;
        pos_next     = pos_reg;
        limit_next   = limit_reg;
        pid_next     = pid_reg;
        hx_next      = hx_reg;
        hy_next      = hy_reg;
        phase_next   = phase_reg;
        emitted_next = emitted_reg;

        if (accept) begin
            if (pos_reg == '0) begin
                limit_next   = (w > pedf_pkg::WORD_W'(pedf_pkg::MAX_PHOTONS)) ?
                               pedf_pkg::MAX_PHOTONS : w[pedf_pkg::COUNT_W-1:0];
                pid_next     = '0;
                emitted_next = '0;
                phase_next   = '0;
            end else if (pos_reg == pedf_pkg::WORD_W'(1)) begin
                pid_next = w;
            end else if (pos_reg >= pedf_pkg::HEADER_WORDS) begin
                case (phase_reg)
                    2'd0: begin
                        hx_next    = w;
                        phase_next = 2'd1;
                    end
                    2'd1: begin
                        hy_next    = w;
                        phase_next = 2'd2;
                    end
                    default: begin
                        if (emitted_reg < limit_reg) begin
                            emitted_next = emitted_reg + pedf_pkg::COUNT_W'(1);
                            hit          = 1'b1;
                        end
                        phase_next = '0;
                    end
                endcase
            end
            if (pos_reg != pedf_pkg::POS_MAX)
                pos_next = pos_reg + pedf_pkg::WORD_W'(1);
        end

        entry.photon        = hit;
        entry.summary       = in_data.end_of_packet;
        entry.x_coord       = hx_reg & pedf_pkg::width_mask(widths.x_width);
        entry.y_coord       = hy_reg & pedf_pkg::width_mask(widths.y_width);
        entry.pulse_height  = w & pedf_pkg::width_mask(widths.pulse_width);
        entry.packet_number = pid_next;
        entry.count         = emitted_next;
        push                = accept && (hit || in_data.end_of_packet);

        // last word: everything back to the start of a packet
        if (accept && in_data.end_of_packet) begin
            pos_next     = '0;
            limit_next   = '0;
            pid_next     = '0;
            hx_next      = '0;
            hy_next      = '0;
            phase_next   = '0;
            emitted_next = '0;
        end
    end

endmodule

@@ rtl/pedf_fifo.sv @@
// Short entry queue between the front end and the output stage.
module pedf_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  pedf_pkg::entry_t        push_data,
    input  logic                    pop,
    output pedf_pkg::entry_t        pop_data,
    output pedf_pkg::fifo_status_t  status
);

    pedf_pkg::entry_t               mem [pedf_pkg::FIFO_DEPTH];
    logic [pedf_pkg::FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [pedf_pkg::FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [pedf_pkg::FIFO_CW-1:0]   count_reg, count_next;

    always_ff @(posedge clk) begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + pedf_pkg::FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + pedf_pkg::FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + pedf_pkg::FIFO_CW'(1);
        else if (pop && !push)
            count_next = count_reg - pedf_pkg::FIFO_CW'(1);
    end

    assign pop_data     = mem[rd_ptr_reg];
    assign status.full  = (count_reg == pedf_pkg::FIFO_CW'(pedf_pkg::FIFO_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

@@ rtl/pedf_back.sv @@
// Output stage: each entry gives a photon word, a summary word or both, photon first.
module pedf_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pedf_pkg::entry_t        head,
    input  logic                    head_valid,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output pedf_pkg::out_item_t     out_data
);

    pedf_pkg::entry_t cur_reg;
    logic             photon_pend_reg, photon_pend_next;
    logic             summary_pend_reg, summary_pend_next;
    logic             last_word;

    always_ff @(posedge clk) begin
        if (pop)
            cur_reg <= head;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            photon_pend_reg  <= 1'b0;
            summary_pend_reg <= 1'b0;
        end else begin
            photon_pend_reg  <= photon_pend_next;
            summary_pend_reg <= summary_pend_next;
        end
    end

    always_comb begin
        out_valid         = photon_pend_reg || summary_pend_reg;
        last_word         = photon_pend_reg ^ summary_pend_reg;
        pop               = head_valid && (!out_valid || (out_ready && last_word));
        photon_pend_next  = photon_pend_reg;
        summary_pend_next = summary_pend_reg;
        if (out_valid && out_ready) begin
            if (photon_pend_reg)
                photon_pend_next = 1'b0;
            else
                summary_pend_next = 1'b0;
        end
        if (pop) begin
            photon_pend_next  = head.photon;
            summary_pend_next = head.summary;
        end
    end

    always_comb begin
        out_data.kind              = photon_pend_reg ? pedf_pkg::KIND_PHOTON
                                                     : pedf_pkg::KIND_SUMMARY;
        out_data.x_coord           = photon_pend_reg ? cur_reg.x_coord : '0;
        out_data.y_coord           = photon_pend_reg ? cur_reg.y_coord : '0;
        out_data.pulse_height      = photon_pend_reg ? cur_reg.pulse_height : '0;
        out_data.packet_number     = cur_reg.packet_number;
        out_data.photons_delivered = cur_reg.count;
    end

endmodule

@@ rtl/photon_event_packet_deframer.sv @@
// Top level of the photon event packet deframer: config registers and datapath.
//
// Usage:
//   in_*  : one 16-bit packet word per handshake, end_of_packet on the last
//           word. Word 0 is the photon count (clamped to 244), word 1 the
//           packet number, word 2 is skipped, then x / y / pulse triples.
//   out_* : a photon word (kind 0) when a triple completes within the
//           clamped count; a summary word (kind 1) after the last word.
//           A word that completes a photon and ends the packet gives both,
//           photon first.
//   APB   : x_width at 0x0, y_width at 0x4, pulse_width at 0x8 (5 bits each,
//           reset 12 / 12 / 8). Write only while the block is idle.
// Throughput: one input word per cycle while the queue is not full; output
//   one word per cycle while out_ready is high.
// Path: front end -> 4-entry queue -> output register.
// Stall: when out_ready is low the queue fills; in_ready drops only when
//   all four queue entries are taken, so words keep flowing across short
//   output stalls.
// Reset: packet state and queue are empty, the next word is taken as word 0.
module photon_event_packet_deframer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  pedf_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output pedf_pkg::out_item_t               out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pedf_pkg::PADDR_W-1:0]      paddr,
    input  logic [pedf_pkg::PDATA_W-1:0]      pwdata,
    output logic [pedf_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    // ---------------- configuration registers ----------------
    logic [pedf_pkg::WIDTH_W-1:0] x_width_reg, y_width_reg, pulse_width_reg;
    logic                         cfg_wr;
    logic [1:0]                   reg_idx;
    pedf_pkg::widths_t            widths;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            x_width_reg     <= pedf_pkg::X_WIDTH_RST;
            y_width_reg     <= pedf_pkg::Y_WIDTH_RST;
            pulse_width_reg <= pedf_pkg::PULSE_WIDTH_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                pedf_pkg::REG_X_WIDTH:     x_width_reg     <= pwdata[pedf_pkg::WIDTH_W-1:0];
                pedf_pkg::REG_Y_WIDTH:     y_width_reg     <= pwdata[pedf_pkg::WIDTH_W-1:0];
                pedf_pkg::REG_PULSE_WIDTH: pulse_width_reg <= pwdata[pedf_pkg::WIDTH_W-1:0];
                default: ;  // unmapped, ignored
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            pedf_pkg::REG_X_WIDTH:     prdata = pedf_pkg::PDATA_W'(x_width_reg);
            pedf_pkg::REG_Y_WIDTH:     prdata = pedf_pkg::PDATA_W'(y_width_reg);
            pedf_pkg::REG_PULSE_WIDTH: prdata = pedf_pkg::PDATA_W'(pulse_width_reg);
            default:                   prdata = '0;
        endcase
    end

    assign widths.x_width     = x_width_reg;
    assign widths.y_width     = y_width_reg;
    assign widths.pulse_width = pulse_width_reg;

    // ---------------- datapath ----------------
    logic                   in_acc;
    logic                   push;
    logic                   pop;
    pedf_pkg::entry_t       push_entry;
    pedf_pkg::entry_t       head_entry;
    pedf_pkg::fifo_status_t fifo_st;

    // Front end runs whenever the queue has a free slot.
    assign in_ready = !fifo_st.full;
    assign in_acc   = in_valid && in_ready;

    pedf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_acc),
        .in_data (in_data),
        .widths  (widths),
        .push    (push),
        .entry   (push_entry)
    );

    pedf_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_entry),
        .pop       (pop),
        .pop_data  (head_entry),
        .status    (fifo_st)
    );

    pedf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_entry),
        .head_valid (!fifo_st.empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    // ---------------- assertions ----------------
    // While work is queued, the output holds a valid word on the next cycle.
    a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
        !fifo_st.empty |=> out_valid)
        else $error("queued entry not presented at output");

    // The last word of a packet always leaves a summary queued.
    a_eop_queued: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_data.end_of_packet |=> !fifo_st.empty)
        else $error("end of packet lost");

    // Delivered count never passes the clamp.
    a_count_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.photons_delivered <= pedf_pkg::MAX_PHOTONS)
        else $error("photon count above clamp");

endmodule
